/* src/cfp_pkg.sv */
// cfp_pkg: shared constants for the circle-from-three-points block
// default coordinate width, threshold register width and reset, tuser bit layout
// no dependencies
package cfp_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int THR_WIDTH = 32;
	localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

	localparam int USER_WIDTH = 2;
	localparam int USER_DEGENERATE = 0;
	localparam int USER_SATURATED = 1;

endpackage

/* src/circle_from_three_points.sv */
// circle_from_three_points: top level, circumcircle of three 2d points
// depends on cfp_pkg, cfp_div_cell, cfp_sqrt_cell
//
// usage:
// a slave beat on s_tdata carries three points (x1,y1,x2,y2,x3,y3), each a
// signed COORD_WIDTH fixed point value. a master beat carries the center,
// the radius, and in m_tuser the degenerate and saturated flags.
// cfg_data sets the collinear threshold on a cfg_valid beat; cfg_ready is
// always high. write it only while the pipeline is empty.
// the pipeline holds six arithmetic stages, a divider chain of COORD_WIDTH+1
// cells, four stages to form the squared distance, a root chain of
// COORD_WIDTH+1 cells and the output register. throughput is one beat per
// cycle unless stalled; every stage is a register with no loop.
// when the receiver stalls, the whole pipeline holds and s_tready drops until
// the output register is taken.
// reset empties the pipeline and sets the threshold to one.
module circle_from_three_points #(
	parameter int COORD_WIDTH = cfp_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// x1, y1, x2, y2, x3, y3
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// center_x, center_y, radius
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// degenerate, saturated
	output logic [cfp_pkg::USER_WIDTH-1:0] m_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cfp_pkg::THR_WIDTH-1:0] cfg_data
);
	import cfp_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int OUT_DW = ((3*W+7)/8)*8;
	localparam int DW1 = W+1;
	localparam int PW = 2*W+2;
	localparam int EW = 2*W+3;
	localparam int LB = W+2;
	localparam int LPW = 2*W+4;
	localparam int HPW = 2*W+2;
	localparam int NW = 3*W+5;
	localparam int DENW = 2*W+4;
	localparam int RW = 3*W+6;
	localparam int QB = W+1;
	localparam int SW = 2*W+2;
	localparam int RB = W+1;

	typedef struct packed {
		logic negx;
		logic negy;
		logic ovfx;
		logic ovfy;
		logic deg;
		logic signed [W-1:0] x1;
		logic signed [W-1:0] y1;
	} div_side_t;

	typedef struct packed {
		logic deg;
		logic sat;
		logic [W-1:0] cx;
		logic [W-1:0] cy;
	} root_side_t;

	logic en;
	logic [THR_WIDTH-1:0] thr_q;

	logic signed [W-1:0] x1, y1, x2, y2, x3, y3;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic signed [DW1-1:0] a_s1, b_s1, c_s1, d_s1, px_s1, py_s1, qx_s1, qy_s1;
	logic signed [W-1:0] x1_s1, y1_s1, x1_s2, y1_s2, x1_s3, y1_s3, x1_s4, y1_s4;
	logic signed [W-1:0] x1_s5, y1_s5;
	logic signed [DW1-1:0] a_s2, b_s2, c_s2, d_s2, a_s3, b_s3, c_s3, d_s3;
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pad_s2, pbc_s2;
	logic signed [EW-1:0] e_s3, f_s3, det_s3, det_s4;
	logic [EW-1:0] adet;
	logic deg_s4, deg_s5;
	logic signed [LPW-1:0] dl_s4, bl_s4, al_s4, cl_s4;
	logic signed [HPW-1:0] dh_s4, bh_s4, ah_s4, ch_s4;
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic signed [DENW-1:0] den_s5;
	logic [NW-1:0] anx, any;
	logic [DENW-1:0] aden;
	logic [RW-1:0] n2x, n2y, d2;
	logic [RW-1:0] n2x_s6, n2y_s6, d2_s6;
	div_side_t side_s6;
	div_side_t dside_q [QB];

	logic vx_w [QB+1];
	logic vy_w [QB+1];
	logic [RW-1:0] remx_w [QB+1];
	logic [RW-1:0] remy_w [QB+1];
	logic [RW-1:0] dvsx_w [QB+1];
	logic [RW-1:0] dvsy_w [QB+1];
	logic [QB-1:0] qx_w [QB+1];
	logic [QB-1:0] qy_w [QB+1];

	logic [QB-1:0] limx, limy, qcx, qcy;
	logic satx, saty;
	logic signed [W-1:0] cx_s7, cy_s7, cx_s8, cy_s8, cx_s9, cy_s9, cx_s10, cy_s10;
	logic signed [W-1:0] x1_s7, y1_s7;
	logic deg_s7, sat_s7, deg_s8, sat_s8, deg_s9, sat_s9, deg_s10, sat_s10;
	logic signed [DW1-1:0] dx_s8, dy_s8;
	logic signed [PW-1:0] sx_s9, sy_s9;
	logic [SW-1:0] s_s10;
	root_side_t rside_q [RB];

	logic rv_w [RB+1];
	logic [SW-1:0] rrem_w [RB+1];
	logic [RB-1:0] root_w [RB+1];

	logic [RB:0] r1;
	logic big;
	logic m_tvalid_q;
	logic [W-1:0] cx_q, cy_q, rad_q;
	logic deg_q, sat_q;

	assign en = !m_tvalid_q || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign x1 = s_tdata[0*W +: W];
	assign y1 = s_tdata[1*W +: W];
	assign x2 = s_tdata[2*W +: W];
	assign y2 = s_tdata[3*W +: W];
	assign x3 = s_tdata[4*W +: W];
	assign y3 = s_tdata[5*W +: W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= vx_w[QB];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			m_tvalid_q <= rv_w[RB];
		end
	end

	// differences, sums, products, determinant
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= DW1'(x1) - DW1'(x2);
			b_s1 <= DW1'(y1) - DW1'(y2);
			c_s1 <= DW1'(x1) - DW1'(x3);
			d_s1 <= DW1'(y1) - DW1'(y3);
			px_s1 <= DW1'(x1) + DW1'(x2);
			py_s1 <= DW1'(y1) + DW1'(y2);
			qx_s1 <= DW1'(x1) + DW1'(x3);
			qy_s1 <= DW1'(y1) + DW1'(y3);
			x1_s1 <= x1;
			y1_s1 <= y1;

			pa_s2 <= PW'(a_s1) * PW'(px_s1);
			pb_s2 <= PW'(b_s1) * PW'(py_s1);
			pc_s2 <= PW'(c_s1) * PW'(qx_s1);
			pd_s2 <= PW'(d_s1) * PW'(qy_s1);
			pad_s2 <= PW'(a_s1) * PW'(d_s1);
			pbc_s2 <= PW'(b_s1) * PW'(c_s1);
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			d_s2 <= d_s1;
			x1_s2 <= x1_s1;
			y1_s2 <= y1_s1;

			e_s3 <= EW'(pa_s2) + EW'(pb_s2);
			f_s3 <= EW'(pc_s2) + EW'(pd_s2);
			det_s3 <= EW'(pad_s2) - EW'(pbc_s2);
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			c_s3 <= c_s2;
			d_s3 <= d_s2;
			x1_s3 <= x1_s2;
			y1_s3 <= y1_s2;

			// e and f split into a low unsigned half and a high signed half
			dl_s4 <= LPW'(d_s3) * LPW'($signed({1'b0, e_s3[LB-1:0]}));
			bl_s4 <= LPW'(b_s3) * LPW'($signed({1'b0, f_s3[LB-1:0]}));
			al_s4 <= LPW'(a_s3) * LPW'($signed({1'b0, f_s3[LB-1:0]}));
			cl_s4 <= LPW'(c_s3) * LPW'($signed({1'b0, e_s3[LB-1:0]}));
			dh_s4 <= HPW'(d_s3) * HPW'($signed(e_s3[EW-1:LB]));
			bh_s4 <= HPW'(b_s3) * HPW'($signed(f_s3[EW-1:LB]));
			ah_s4 <= HPW'(a_s3) * HPW'($signed(f_s3[EW-1:LB]));
			ch_s4 <= HPW'(c_s3) * HPW'($signed(e_s3[EW-1:LB]));
			det_s4 <= det_s3;
			deg_s4 <= (det_s3 == '0) || (adet < {{(EW-THR_WIDTH){1'b0}}, thr_q});
			x1_s4 <= x1_s3;
			y1_s4 <= y1_s3;

			nx_s5 <= ((NW'(dh_s4) - NW'(bh_s4)) <<< LB) + NW'(dl_s4) - NW'(bl_s4);
			ny_s5 <= ((NW'(ah_s4) - NW'(ch_s4)) <<< LB) + NW'(al_s4) - NW'(cl_s4);
			den_s5 <= DENW'(det_s4) <<< 1;
			deg_s5 <= deg_s4;
			x1_s5 <= x1_s4;
			y1_s5 <= y1_s4;

			n2x_s6 <= n2x;
			n2y_s6 <= n2y;
			d2_s6 <= d2;
			side_s6.negx <= nx_s5[NW-1] ^ den_s5[DENW-1];
			side_s6.negy <= ny_s5[NW-1] ^ den_s5[DENW-1];
			side_s6.ovfx <= n2x >= (d2 << QB);
			side_s6.ovfy <= n2y >= (d2 << QB);
			side_s6.deg <= deg_s5;
			side_s6.x1 <= x1_s5;
			side_s6.y1 <= y1_s5;
		end
	end

	always_comb begin
		adet = det_s3[EW-1] ? EW'(-det_s3) : EW'(det_s3);
		anx = nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
		any = ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
		aden = den_s5[DENW-1] ? DENW'(-den_s5) : DENW'(den_s5);
		// round to nearest: (2|n| + |den|) / (2|den|)
		n2x = (RW'(anx) << 1) + RW'(aden);
		n2y = (RW'(any) << 1) + RW'(aden);
		d2 = RW'(aden) << 1;
	end

	// divider chains, one quotient bit per cell
	assign vx_w[0] = v_s6;
	assign vy_w[0] = v_s6;
	assign remx_w[0] = n2x_s6;
	assign remy_w[0] = n2y_s6;
	assign dvsx_w[0] = d2_s6;
	assign dvsy_w[0] = d2_s6;
	assign qx_w[0] = '0;
	assign qy_w[0] = '0;

	for (genvar i = 0; i < QB; i++) begin : g_div
		cfp_div_cell #(.COORD_WIDTH(W), .BIT(QB-1-i)) u_div_x (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vx_w[i]), .rem_in(remx_w[i]), .dvs_in(dvsx_w[i]), .quo_in(qx_w[i]),
			.vld_out(vx_w[i+1]), .rem_out(remx_w[i+1]), .dvs_out(dvsx_w[i+1]),
			.quo_out(qx_w[i+1])
		);
		cfp_div_cell #(.COORD_WIDTH(W), .BIT(QB-1-i)) u_div_y (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vy_w[i]), .rem_in(remy_w[i]), .dvs_in(dvsy_w[i]), .quo_in(qy_w[i]),
			.vld_out(vy_w[i+1]), .rem_out(remy_w[i+1]), .dvs_out(dvsy_w[i+1]),
			.quo_out(qy_w[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dside_q[0] <= side_s6;
			for (int i = 1; i < QB; i++) begin
				dside_q[i] <= dside_q[i-1];
			end
		end
	end

	// clamp, sign, then squared distance from the first point
	always_comb begin
		limx = dside_q[QB-1].negx ? (QB'(1) << (W-1)) : ((QB'(1) << (W-1)) - QB'(1));
		limy = dside_q[QB-1].negy ? (QB'(1) << (W-1)) : ((QB'(1) << (W-1)) - QB'(1));
		satx = dside_q[QB-1].ovfx || (qx_w[QB] > limx);
		saty = dside_q[QB-1].ovfy || (qy_w[QB] > limy);
		qcx = satx ? limx : qx_w[QB];
		qcy = saty ? limy : qy_w[QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s7 <= dside_q[QB-1].negx ? W'(-qcx) : W'(qcx);
			cy_s7 <= dside_q[QB-1].negy ? W'(-qcy) : W'(qcy);
			sat_s7 <= satx || saty;
			deg_s7 <= dside_q[QB-1].deg;
			x1_s7 <= dside_q[QB-1].x1;
			y1_s7 <= dside_q[QB-1].y1;

			dx_s8 <= DW1'(x1_s7) - DW1'(cx_s7);
			dy_s8 <= DW1'(y1_s7) - DW1'(cy_s7);
			cx_s8 <= cx_s7;
			cy_s8 <= cy_s7;
			sat_s8 <= sat_s7;
			deg_s8 <= deg_s7;

			sx_s9 <= PW'(dx_s8) * PW'(dx_s8);
			sy_s9 <= PW'(dy_s8) * PW'(dy_s8);
			cx_s9 <= cx_s8;
			cy_s9 <= cy_s8;
			sat_s9 <= sat_s8;
			deg_s9 <= deg_s8;

			s_s10 <= SW'(sx_s9) + SW'(sy_s9);
			cx_s10 <= cx_s9;
			cy_s10 <= cy_s9;
			sat_s10 <= sat_s9;
			deg_s10 <= deg_s9;
		end
	end

	// root chain, one bit per cell
	assign rv_w[0] = v_s10;
	assign rrem_w[0] = s_s10;
	assign root_w[0] = '0;

	for (genvar i = 0; i < RB; i++) begin : g_root
		cfp_sqrt_cell #(.COORD_WIDTH(W), .BIT(RB-1-i)) u_sqrt (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(rv_w[i]), .rem_in(rrem_w[i]), .root_in(root_w[i]),
			.vld_out(rv_w[i+1]), .rem_out(rrem_w[i+1]), .root_out(root_w[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rside_q[0] <= '{deg: deg_s10, sat: sat_s10, cx: cx_s10, cy: cy_s10};
			for (int i = 1; i < RB; i++) begin
				rside_q[i] <= rside_q[i-1];
			end
		end
	end

	always_comb begin
		r1 = (RB+1)'(root_w[RB]) + (RB+1)'(rrem_w[RB] > SW'(root_w[RB]));
		big = r1[RB:W] != '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rside_q[RB-1].deg) begin
				cx_q <= '0;
				cy_q <= '0;
				rad_q <= '1;
				deg_q <= 1'b1;
				sat_q <= 1'b0;
			end else begin
				cx_q <= rside_q[RB-1].cx;
				cy_q <= rside_q[RB-1].cy;
				rad_q <= (rside_q[RB-1].sat || big) ? '1 : r1[W-1:0];
				deg_q <= 1'b0;
				sat_q <= rside_q[RB-1].sat || big;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = OUT_DW'({rad_q, cy_q, cx_q});
	always_comb begin
		m_tuser = '0;
		m_tuser[USER_DEGENERATE] = deg_q;
		m_tuser[USER_SATURATED] = sat_q;
	end

	a_deg_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[USER_DEGENERATE] && m_tuser[USER_SATURATED]))
		else $error("degenerate beat flagged saturated");

	a_deg_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[USER_DEGENERATE]) |-> (cx_q == '0 && cy_q == '0 && rad_q == '1))
		else $error("degenerate beat with nonzero center or short radius");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output beat changed while stalled");

endmodule

/* src/cfp_div_cell.sv */
// cfp_div_cell: one quotient bit of a restoring divider chain
// depends on cfp_pkg for the default width
module cfp_div_cell #(
	parameter int COORD_WIDTH = cfp_pkg::COORD_WIDTH_DEF,
	parameter int BIT = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_in,
	input  logic [3*COORD_WIDTH+5:0] rem_in,
	input  logic [3*COORD_WIDTH+5:0] dvs_in,
	input  logic [COORD_WIDTH:0]     quo_in,
	output logic                     vld_out,
	output logic [3*COORD_WIDTH+5:0] rem_out,
	output logic [3*COORD_WIDTH+5:0] dvs_out,
	output logic [COORD_WIDTH:0]     quo_out
);
	localparam int RW = 3*COORD_WIDTH+6;

	logic [RW-1:0] shifted;
	logic [RW-1:0] diff;
	logic ge;
	logic [COORD_WIDTH:0] quo_nx;
	logic vld_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dvs_q;
	logic [COORD_WIDTH:0] quo_q;

	always_comb begin
		shifted = dvs_in << BIT;
		ge = rem_in >= shifted;
		diff = rem_in - shifted;
		quo_nx = quo_in;
		quo_nx[BIT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff : rem_in;
			dvs_q <= dvs_in;
			quo_q <= quo_nx;
		end
	end

	assign vld_out = vld_q;
	assign rem_out = rem_q;
	assign dvs_out = dvs_q;
	assign quo_out = quo_q;

endmodule

/* src/cfp_sqrt_cell.sv */
// cfp_sqrt_cell: one root bit of a shift-subtract square root chain
// depends on cfp_pkg for the default width
module cfp_sqrt_cell #(
	parameter int COORD_WIDTH = cfp_pkg::COORD_WIDTH_DEF,
	parameter int BIT = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_in,
	input  logic [2*COORD_WIDTH+1:0] rem_in,
	input  logic [COORD_WIDTH:0]     root_in,
	output logic                     vld_out,
	output logic [2*COORD_WIDTH+1:0] rem_out,
	output logic [COORD_WIDTH:0]     root_out
);
	localparam int SW = 2*COORD_WIDTH+2;
	localparam int RB = COORD_WIDTH+1;

	logic [SW:0] trial;
	logic [SW:0] diff;
	logic ge;
	logic [RB-1:0] root_nx;
	logic vld_q;
	logic [SW-1:0] rem_q;
	logic [RB-1:0] root_q;

	// rem holds s - root^2; adding bit k to root costs root*2^(k+1) + 2^(2k)
	always_comb begin
		trial = ({{(SW-RB+1){1'b0}}, root_in} << (BIT+1)) + ((SW+1)'(1) << (2*BIT));
		ge = {1'b0, rem_in} >= trial;
		diff = {1'b0, rem_in} - trial;
		root_nx = root_in;
		root_nx[BIT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[SW-1:0] : rem_in;
			root_q <= root_nx;
		end
	end

	assign vld_out = vld_q;
	assign rem_out = rem_q;
	assign root_out = root_q;

endmodule

/* dv/circle_from_three_points_tb.sv */
// circle_from_three_points_tb: self-checking bench for the circumcircle block
// directed table then random point triples, checked against a wide-integer predictor
// depends on cfp_pkg and circle_from_three_points
module circle_from_three_points_tb;
	import cfp_pkg::*;

	localparam int CW = 32;
	localparam int LATENCY = 2*CW+13;
	localparam int LIMIT = 600000;
	localparam int SEG_ITEMS = 300;

	typedef logic signed [191:0] wide_t;

	typedef struct packed {
		logic [CW-1:0] y3, x3, y2, x2, y1, x1;
	} triple_t;

	typedef struct packed {
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic [CW-1:0] rad;
		logic degen;
		logic sat;
	} circle_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [6*CW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [3*CW-1:0] m_tdata;
	logic [USER_WIDTH-1:0] m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [THR_WIDTH-1:0] cfg_data = '0;

	logic [THR_WIDTH-1:0] threshold = THR_RESET;
	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	int cycles = 0;
	circle_t circles_due[$];

	triple_t dir_pts[$];
	circle_t dir_exp[$];
	bit dir_known[$];

	circle_from_three_points u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("circle_from_three_points_tb: done, errors");
			$finish;
		end
	end

	function automatic wide_t widen(input logic [CW-1:0] v);
		return {{(192-CW){v[CW-1]}}, v};
	endfunction

	function automatic wide_t wabs(input wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [CW-1:0] div_round(input wide_t num, input wide_t den,
			inout logic sat);
		logic neg;
		wide_t q, lim;
		neg = (num < 0) != (den < 0);
		q = (2*wabs(num) + wabs(den)) / (2*wabs(den));
		lim = neg ? (wide_t'(1) <<< (CW-1)) : (wide_t'(1) <<< (CW-1)) - 1;
		if (q > lim) begin
			sat = 1;
			q = lim;
		end
		if (neg)
			q = -q;
		return q[CW-1:0];
	endfunction

	function automatic circle_t predict_circle(input triple_t p, input logic [THR_WIDTH-1:0] thr);
		wide_t x1, y1, x2, y2, x3, y3, a, b, c, d, e, f, det, nx, ny, dx, dy, s, rem;
		logic [CW+1:0] r, cand;
		circle_t o;
		x1 = widen(p.x1); y1 = widen(p.y1);
		x2 = widen(p.x2); y2 = widen(p.y2);
		x3 = widen(p.x3); y3 = widen(p.y3);
		a = x1 - x2; b = y1 - y2; c = x1 - x3; d = y1 - y3;
		e = a*(x1 + x2) + b*(y1 + y2);
		f = c*(x1 + x3) + d*(y1 + y3);
		det = a*d - b*c;
		o = '0;
		if (det == 0 || wabs(det) < wide_t'({160'b0, thr})) begin
			o.rad = '1;
			o.degen = 1;
			return o;
		end
		nx = d*e - b*f;
		ny = a*f - c*e;
		o.cx = div_round(nx, 2*det, o.sat);
		o.cy = div_round(ny, 2*det, o.sat);
		if (o.sat) begin
			o.rad = '1;
			return o;
		end
		dx = x1 - widen(o.cx);
		dy = y1 - widen(o.cy);
		s = dx*dx + dy*dy;
		r = '0;
		for (int bt = CW; bt >= 0; bt--) begin
			cand = r | ((CW+2)'(1) << bt);
			if (wide_t'({158'b0, cand}) * wide_t'({158'b0, cand}) <= s)
				r = cand;
		end
		rem = s - wide_t'({158'b0, r}) * wide_t'({158'b0, r});
		if (rem > wide_t'({158'b0, r}))
			r = r + 1;
		if (r > {2'b0, {CW{1'b1}}}) begin
			o.rad = '1;
			o.sat = 1;
		end else begin
			o.rad = r[CW-1:0];
		end
		return o;
	endfunction

	always @(posedge clk) begin
		circle_t got, want;
		m_tready <= ($urandom_range(99) >= recv_idle);
		if (m_tvalid && m_tready) begin
			got.cx = m_tdata[CW-1:0];
			got.cy = m_tdata[2*CW-1:CW];
			got.rad = m_tdata[3*CW-1:2*CW];
			got.degen = m_tuser[USER_DEGENERATE];
			got.sat = m_tuser[USER_SATURATED];
			if (circles_due.size() == 0) begin
				$display("%0t: unexpected beat cx=%h cy=%h r=%h deg=%b sat=%b",
					$time, got.cx, got.cy, got.rad, got.degen, got.sat);
				errors++;
			end else begin
				want = circles_due.pop_front();
				if (got.cx !== want.cx) begin
					$display("%0t: center_x exp %h got %h", $time, want.cx, got.cx);
					errors++;
				end
				if (got.cy !== want.cy) begin
					$display("%0t: center_y exp %h got %h", $time, want.cy, got.cy);
					errors++;
				end
				if (got.rad !== want.rad) begin
					$display("%0t: radius exp %h got %h", $time, want.rad, got.rad);
					errors++;
				end
				if (got.degen !== want.degen) begin
					$display("%0t: degenerate exp %b got %b", $time, want.degen, got.degen);
					errors++;
				end
				if (got.sat !== want.sat) begin
					$display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
					errors++;
				end
			end
		end
	end

	task automatic send_triple(input triple_t p, input bit known, input circle_t exp_c);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {p.y3, p.x3, p.y2, p.x2, p.y1, p.x1};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		circles_due.push_back(known ? exp_c : predict_circle(p, threshold));
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (circles_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_WIDTH-1:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		threshold = v;
	endtask

	function automatic logic [CW-1:0] small_coord();
		logic [CW-1:0] v;
		v = $urandom;
		return {{(CW-20){v[19]}}, v[19:0]};
	endfunction

	function automatic logic [CW-1:0] edge_coord();
		case ($urandom_range(5))
			0: return {1'b1, {(CW-1){1'b0}}};
			1: return {1'b0, {(CW-1){1'b1}}};
			2: return '0;
			3: return '1;
			4: return 1;
			default: return $urandom;
		endcase
	endfunction

	function automatic triple_t random_triple();
		triple_t p;
		logic [CW-1:0] ux, uy, k;
		case ($urandom_range(9))
			0, 1, 2: p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			3, 4, 5: p = {small_coord(), small_coord(), small_coord(),
				small_coord(), small_coord(), small_coord()};
			6, 7, 8: begin
				p.x1 = small_coord(); p.y1 = small_coord();
				ux = $urandom_range(2047) - 1024; uy = $urandom_range(2047) - 1024;
				k = $urandom_range(64) - 32;
				p.x2 = p.x1 + ux; p.y2 = p.y1 + uy;
				p.x3 = p.x1 + k*ux; p.y3 = p.y1 + k*uy;
				if ($urandom_range(2) == 0) begin
					p.x3 = p.x3 + $urandom_range(2) - 1;
					p.y3 = p.y3 + $urandom_range(2) - 1;
				end
			end
			default: p = {edge_coord(), edge_coord(), edge_coord(),
				edge_coord(), edge_coord(), edge_coord()};
		endcase
		return p;
	endfunction

	task automatic add_row(input triple_t p, input bit known, input circle_t c);
		dir_pts.push_back(p);
		dir_known.push_back(known);
		dir_exp.push_back(c);
	endtask

	initial begin
		logic [CW-1:0] mx, mn, one;
		circle_t degen_c, tri_c;
		logic [THR_WIDTH-1:0] thr_plan[6];
		mx = {1'b0, {(CW-1){1'b1}}};
		mn = {1'b1, {(CW-1){1'b0}}};
		one = 32'h0001_0000;
		degen_c = '{cx: '0, cy: '0, rad: '1, degen: 1, sat: 0};
		tri_c = '{cx: one, cy: one, rad: 32'h0001_6A0A, degen: 0, sat: 0};
		thr_plan = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h1, $urandom, $urandom};

		add_row('0, 1, degen_c);
		add_row({2*one, 2*one, one, one, 32'h0, 32'h0}, 1, degen_c);
		add_row({mx, mx, mx, mx, mx, mx}, 1, degen_c);
		add_row({mn, mn, mn, mn, mn, mn}, 1, degen_c);
		add_row({2*one, 32'h0, 32'h0, 2*one, 32'h0, 32'h0}, 1, tri_c);
		add_row({mx, mn, mn, mx, mx, mn}, 0, '0);
		add_row({mn, mx, mx, mn, mn, mx}, 0, '0);
		add_row({mx, mx, mn, mx, mx, mn}, 0, '0);
		add_row({32'h1, 32'h7FFF_0000, 32'h0, one, 32'h0, 32'h0}, 0, '0);
		add_row({32'h1, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0}, 0, '0);
		add_row({32'h0, 32'h1, 32'h1, 32'h0, 32'h0, 32'h0}, 0, '0);
		add_row({32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0}, 0, '0);
		add_row({mn, 32'h0, 32'h0, mx, mn, mx}, 0, '0);
		add_row({32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h5555_5555, 32'hAAAA_AAAA}, 0, '0);
		add_row({3*one, 32'h0, 32'h0, 4*one, 32'hFFFD_0000, 32'h0}, 0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_idle = 28; recv_idle = 64;
		foreach (dir_pts[i])
			send_triple(dir_pts[i], dir_known[i], dir_exp[i]);

		for (int seg = 0; seg < 6; seg++) begin
			write_threshold(thr_plan[seg]);
			case (seg % 3)
				0: begin send_idle = 28; recv_idle = 64; end
				1: begin send_idle = 64; recv_idle = 28; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int n = 0; n < SEG_ITEMS; n++) begin
				if (n == SEG_ITEMS/2 && seg == 2) begin
					s_tvalid <= 0;
					while (circles_due.size() != 0)
						@(posedge clk);
				end
				send_triple(random_triple(), 0, '0);
			end
		end

		drain();
		if (errors == 0)
			$display("circle_from_three_points_tb: done, clean");
		else
			$display("circle_from_three_points_tb: done, errors");
		$finish;
	end

endmodule
